/* rtl/ups_hps_pkg.sv */
// ----------------------------------------------------------------------------
// ups_hps_pkg
// Shared widths, register indexes, sequencer state codes and word types.
// ----------------------------------------------------------------------------
package ups_hps_pkg;

  localparam int unsigned ADC_BITS  = 10;
  localparam int unsigned TIME_BITS = 32;
  localparam int unsigned DLY_BITS  = 16;
  localparam int unsigned ST_BITS   = 3;

  // config port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = DLY_BITS;
  localparam logic [CFG_IDX_BITS-1:0] CFG_AC_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OFF_DELAY    = 1'd1;

  localparam logic [ADC_BITS-1:0] AC_THRESHOLD_RST = ADC_BITS'(824);
  localparam logic [DLY_BITS-1:0] OFF_DELAY_RST    = DLY_BITS'(5000);

  // stream word widths
  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 16;

  // sequencer state codes
  localparam logic [ST_BITS-1:0] ST_START       = 3'd0;
  localparam logic [ST_BITS-1:0] ST_WAIT_ON     = 3'd1;
  localparam logic [ST_BITS-1:0] ST_WAIT_OFF    = 3'd2;
  localparam logic [ST_BITS-1:0] ST_DELAY       = 3'd3;
  localparam logic [ST_BITS-1:0] ST_WAIT_BUTTON = 3'd4;
  localparam logic [ST_BITS-1:0] ST_WAIT_POWER  = 3'd5;
  localparam logic [ST_BITS-1:0] ST_SETTLE      = 3'd6;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic                 button_level;
    logic                 sample_strobe;
    logic [ADC_BITS-1:0]  supply_code;
    logic                 host_online_level;
  } in_item_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] ac_threshold_code;
    logic [DLY_BITS-1:0] off_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic               host_power_on;
    logic               power_wait_flag;
    logic               powerfail_shutdown;
    logic               mains_flag;
    logic               battery_flag;
    logic               button_flag;
    logic               host_online_flag;
    logic [ST_BITS-1:0] sequencer_state;
  } result_t;

endpackage

/* rtl/ups_host_power_sequencer.sv */
// ----------------------------------------------------------------------------
// ups_host_power_sequencer
// Host power sequencer for a battery-backed supply, one loop pass per word.
// ----------------------------------------------------------------------------
// Each input word is one pass of the control loop. The word lands in an
// input register, the sequencer update runs in combinational logic behind
// it and the status lands in an output register, so a word is accepted
// every cycle while the output is not stalled. Its status reaches the
// output through the input and output registers and stays until taken.
// Throughput is one word per clock while the output is not stalled; a
// stalled output holds the pipe. Configuration (mains threshold code, off
// delay in ms) is written through cfg_we_i / cfg_index_i / cfg_wdata_i;
// the user must do so only while the block is idle, which the block itself
// does not enforce. Deadlines compare wrap-safe modulo 2^32.
// ----------------------------------------------------------------------------
module ups_host_power_sequencer
  import ups_hps_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [31:0] now_ms, [32] button_level, [42:33] supply_code,
  // [43] host_online_level, [47:44] zero
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // [0] sample_strobe
  input  logic                     s_axis_tuser,
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [0] host_power_on, [1] power_wait_flag, [2] powerfail_shutdown,
  // [3] mains_flag, [4] battery_flag, [5] button_flag,
  // [6] host_online_flag, [9:7] sequencer_state, [15:10] zero
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  cfg_t     cfg_q;
  in_item_t item_q;
  logic     in_vld_q;
  result_t  res_d;
  result_t  res_q;
  logic     out_vld_q;
  logic     step;
  logic     take;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ac_threshold_code <= AC_THRESHOLD_RST;
      cfg_q.off_delay_ms      <= OFF_DELAY_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_AC_THRESHOLD: cfg_q.ac_threshold_code <= cfg_wdata_i[ADC_BITS-1:0];
        CFG_OFF_DELAY:    cfg_q.off_delay_ms      <= cfg_wdata_i[DLY_BITS-1:0];
        default: ;
      endcase
    end
  end

  // word advances when the output register is free or being drained
  assign step          = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || step;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take)      in_vld_q <= 1'b1;
      else if (step) in_vld_q <= 1'b0;
      if (step)               out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.now_ms            <= s_axis_tdata[TIME_BITS-1:0];
      item_q.button_level      <= s_axis_tdata[TIME_BITS];
      item_q.supply_code       <= s_axis_tdata[TIME_BITS+ADC_BITS:TIME_BITS+1];
      item_q.host_online_level <= s_axis_tdata[TIME_BITS+ADC_BITS+1];
      item_q.sample_strobe     <= s_axis_tuser;
    end
    if (step) res_q <= res_d;
  end

  ups_hps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.sequencer_state, res_q.host_online_flag,
                          res_q.button_flag, res_q.battery_flag, res_q.mains_flag,
                          res_q.powerfail_shutdown, res_q.power_wait_flag,
                          res_q.host_power_on};

endmodule

/* rtl/ups_hps_seq.sv */
// ----------------------------------------------------------------------------
// ups_hps_seq
// Button release detect, supply/online latches and host power sequencer.
// ----------------------------------------------------------------------------
module ups_hps_seq
  import ups_hps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,    // commit one word
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  output result_t  res_o      // status after this word's update
);

  logic [ST_BITS-1:0]   state_q, state_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic power_q, power_d;
  logic wait_q, wait_d;
  logic pf_q, pf_d;
  logic mains_q, mains_d;
  logic batt_q, batt_d;
  logic online_q, online_d;
  logic held_q, held_d;

  logic                 released;
  logic [TIME_BITS-1:0] armed;
  logic [TIME_BITS-1:0] diff;
  logic                 passed;

  always_comb begin
    // release pulse
    released = 1'b0;
    held_d   = held_q;
    if (!item_i.button_level) begin
      held_d = 1'b1;
    end else if (held_q) begin
      released = 1'b1;
      held_d   = 1'b0;
    end

    online_d = online_q;
    mains_d  = mains_q;
    batt_d   = batt_q;
    if (item_i.sample_strobe) begin
      online_d = item_i.host_online_level;
      mains_d  = (item_i.supply_code >= cfg_i.ac_threshold_code);
      batt_d   = (item_i.supply_code < cfg_i.ac_threshold_code);
    end
  end

  // wrap-safe deadline arithmetic
  assign armed  = item_i.now_ms + TIME_BITS'(cfg_i.off_delay_ms);
  assign diff   = item_i.now_ms - deadline_q;
  assign passed = (diff != '0) && !diff[TIME_BITS-1];

  always_comb begin
    state_d    = state_q;
    deadline_d = deadline_q;
    power_d    = power_q;
    wait_d     = wait_q;
    pf_d       = pf_q;
    case (state_q)
      ST_START: begin
        if (!mains_d) begin
          pf_d    = 1'b1;
          state_d = ST_WAIT_POWER;
        end else begin
          wait_d  = !power_q;
          power_d = 1'b1;
          state_d = ST_WAIT_ON;
        end
      end
      ST_WAIT_ON: begin
        if (online_d) state_d = ST_WAIT_OFF;
      end
      ST_WAIT_OFF: begin
        if (!online_d) begin
          deadline_d = armed;
          state_d    = ST_DELAY;
        end
      end
      ST_DELAY: begin
        if (online_d) begin
          state_d = ST_WAIT_OFF;
        end else if (passed) begin
          wait_d  = power_q;
          power_d = 1'b0;
          if (batt_d) begin
            pf_d    = 1'b1;
            state_d = ST_WAIT_POWER;
          end else begin
            state_d = ST_WAIT_BUTTON;
          end
        end
      end
      ST_WAIT_BUTTON: begin
        if (released) begin
          wait_d  = !power_q;
          power_d = 1'b1;
          state_d = ST_WAIT_ON;
        end
      end
      ST_WAIT_POWER: begin
        if (mains_d) begin
          deadline_d = armed;
          state_d    = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (!mains_d) begin
          deadline_d = armed;
        end else if (passed) begin
          wait_d  = !power_q;
          power_d = 1'b1;
          state_d = ST_WAIT_ON;
        end
      end
      default: begin
        state_d = ST_WAIT_ON;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_START;
      power_q  <= 1'b0;
      wait_q   <= 1'b0;
      pf_q     <= 1'b0;
      mains_q  <= 1'b0;
      batt_q   <= 1'b0;
      online_q <= 1'b0;
      held_q   <= 1'b1;
    end else if (step_i) begin
      state_q  <= state_d;
      power_q  <= power_d;
      wait_q   <= wait_d;
      pf_q     <= pf_d;
      mains_q  <= mains_d;
      batt_q   <= batt_d;
      online_q <= online_d;
      held_q   <= held_d;
    end
  end

  // deadline is always armed before it is compared
  always_ff @(posedge clk_i) begin
    if (step_i) deadline_q <= deadline_d;
  end

  assign res_o.host_power_on      = power_d;
  assign res_o.power_wait_flag    = wait_d;
  assign res_o.powerfail_shutdown = pf_d;
  assign res_o.mains_flag         = mains_d;
  assign res_o.battery_flag       = batt_d;
  assign res_o.button_flag        = held_d;
  assign res_o.host_online_flag   = online_d;
  assign res_o.sequencer_state    = state_d;

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(state_q) && $stable(power_q) && $stable(held_q))
    else $error("sequencer state moved without a committed word");

  a_power_rise_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(power_q) |-> wait_q)
    else $error("power switched on without wait flag");

  a_wait_power_pf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT_POWER) |-> pf_q)
    else $error("waiting for mains without power-fail flag");

  a_mains_batt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mains_q && batt_q))
    else $error("mains and battery flags both set");

  a_delay_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DELAY || state_q == ST_WAIT_OFF) |-> power_q)
    else $error("host unpowered while waiting for it to go offline");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: host power sequencer testbench
// Drives loop-pass words into the sequencer, checks every status word against
// an in-bench model or, for pinned rows, the pinned status. A short table of
// directed passes is followed by random but plausible supply, host and button
// activity under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top
  import ups_hps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000; // cycles with no word moving
  localparam int unsigned SEG_WORDS  = 315;  // random words per setting
  localparam int unsigned N_SEGS     = 6;
  localparam int unsigned N_PROBES   = 23;

  // one row of the directed table: pass contents, pin flag, pinned status
  typedef struct packed {
    in_item_t pass;
    logic     pinned;
    result_t  status;
  } probe_t;

  localparam result_t NO_STATUS = '0;

  // Status bits below read left to right:
  //   power on, power changed, powerfail, mains, battery, button held, online
  localparam probe_t PROBES [N_PROBES] = '{
    // no sample yet: start state sees no mains, goes to wait power
    {32'h0000_0000, 1'b1, 1'b0, 10'd0,    1'b0, 1'b1, 7'b0010000, ST_WAIT_POWER},
    // one code below threshold is battery
    {32'h0000_000a, 1'b0, 1'b1, 10'd823,  1'b0, 1'b1, 7'b0010110, ST_WAIT_POWER},
    // threshold itself is mains, settle armed for 5020
    {32'h0000_0014, 1'b0, 1'b1, 10'd824,  1'b0, 1'b1, 7'b0011010, ST_SETTLE},
    // deadline reached exactly is not yet passed; button release
    {32'h0000_139c, 1'b1, 1'b0, 10'd0,    1'b0, 1'b1, 7'b0011000, ST_SETTLE},
    {32'h0000_139d, 1'b1, 1'b0, 10'd0,    1'b0, 1'b1, 7'b1111000, ST_WAIT_ON},
    {32'h0000_13a6, 1'b1, 1'b1, 10'd1023, 1'b1, 1'b1, 7'b1111001, ST_WAIT_OFF},
    // host drops at the top of the time range, deadline wraps to 4999
    {32'hffff_ffff, 1'b1, 1'b1, 10'd1023, 1'b0, 1'b1, 7'b1111000, ST_DELAY},
    {32'h0000_1386, 1'b0, 1'b0, 10'd0,    1'b0, 1'b1, 7'b1111010, ST_DELAY},
    // exactly half the time range beyond: not passed
    {32'h8000_1387, 1'b0, 1'b0, 10'd0,    1'b0, 1'b1, 7'b1111010, ST_DELAY},
    // just under half beyond: passed, on mains so wait for button
    {32'h8000_1386, 1'b0, 1'b0, 10'd0,    1'b0, 1'b1, 7'b0111010, ST_WAIT_BUTTON},
    {32'h8000_1400, 1'b0, 1'b0, 10'd0,    1'b0, 1'b0, NO_STATUS},
    {32'h8000_1401, 1'b1, 1'b0, 10'd0,    1'b0, 1'b0, NO_STATUS},
    {32'h8000_1402, 1'b1, 1'b1, 10'd900,  1'b1, 1'b0, NO_STATUS},
    // host off, back on inside the delay, off again
    {32'h0000_0064, 1'b1, 1'b1, 10'd900,  1'b0, 1'b0, NO_STATUS},
    {32'h0000_00c8, 1'b1, 1'b1, 10'd900,  1'b1, 1'b0, NO_STATUS},
    {32'h0000_012c, 1'b1, 1'b1, 10'd900,  1'b0, 1'b0, NO_STATUS},
    // mains lost during the delay: power fail path
    {32'h0000_0190, 1'b1, 1'b1, 10'd0,    1'b0, 1'b0, NO_STATUS},
    {32'h0000_14b5, 1'b1, 1'b0, 10'd0,    1'b0, 1'b0, NO_STATUS},
    // mains back, dips during settle (re-armed), then holds
    {32'h0000_1518, 1'b0, 1'b1, 10'd824,  1'b0, 1'b0, NO_STATUS},
    {32'h0000_157c, 1'b0, 1'b1, 10'd100,  1'b0, 1'b0, NO_STATUS},
    {32'h0000_28d2, 1'b1, 1'b1, 10'd1000, 1'b0, 1'b0, NO_STATUS},
    {32'h0000_2905, 1'b1, 1'b0, 10'd1023, 1'b1, 1'b0, NO_STATUS},
    {32'h0000_2968, 1'b1, 1'b0, 10'd1023, 1'b1, 1'b0, NO_STATUS}
  };

  localparam logic [ADC_BITS-1:0] THR_SET [N_SEGS] = '{
    10'd824, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd1000
  };
  localparam logic [DLY_BITS-1:0] DLY_SET [N_SEGS] = '{
    16'd5000, 16'd0, 16'd65535, 16'd17, 16'd1, 16'd300
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  // [31:0] now_ms, [32] button_level, [42:33] supply_code,
  // [43] host_online_level, [47:44] zero
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  // [0] sample_strobe
  logic                     s_axis_tuser;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  // [0] host_power_on, [1] power_wait_flag, [2] powerfail_shutdown,
  // [3] mains_flag, [4] battery_flag, [5] button_flag,
  // [6] host_online_flag, [9:7] sequencer_state, [15:10] zero
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  ups_host_power_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Sequencer model: own copy of registers and state
  // --------------------------------------------------------------------------
  logic [ADC_BITS-1:0]  thr_cfg = AC_THRESHOLD_RST;
  logic [DLY_BITS-1:0]  dly_cfg = OFF_DELAY_RST;

  logic [ST_BITS-1:0]   seq_st      = ST_START;
  logic [TIME_BITS-1:0] due_ms      = '0;
  logic                 pwr_on      = 1'b0;
  logic                 pwr_changed = 1'b0;
  logic                 pf_sticky   = 1'b0;
  logic                 mains_on    = 1'b0;
  logic                 on_battery  = 1'b0;
  logic                 host_up     = 1'b0;
  logic                 btn_held    = 1'b1;

  logic [6:0]           states_seen = '0;

  function automatic void switch_power(input logic on);
    pwr_changed = (pwr_on != on);
    pwr_on      = on;
  endfunction

  // wrap-safe: passed when now is 1 .. 2^31-1 ms beyond the deadline
  function automatic logic overdue(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] d;
    d = now - due_ms;
    return (d != '0) && !d[TIME_BITS-1];
  endfunction

  // one loop pass: button, latches, then the sequencer
  function automatic result_t loop_pass(input in_item_t w);
    logic    released;
    result_t r;
    released = 1'b0;
    if (!w.button_level) begin
      btn_held = 1'b1;
    end else if (btn_held) begin
      released = 1'b1;
      btn_held = 1'b0;
    end
    if (w.sample_strobe) begin
      host_up    = w.host_online_level;
      mains_on   = (w.supply_code >= thr_cfg);
      on_battery = !mains_on;
    end
    case (seq_st)
      ST_START: begin
        if (!mains_on) begin
          pf_sticky = 1'b1;
          seq_st    = ST_WAIT_POWER;
        end else begin
          switch_power(1'b1);
          seq_st = ST_WAIT_ON;
        end
      end
      ST_WAIT_ON: begin
        if (host_up) seq_st = ST_WAIT_OFF;
      end
      ST_WAIT_OFF: begin
        if (!host_up) begin
          due_ms = w.now_ms + TIME_BITS'(dly_cfg);
          seq_st = ST_DELAY;
        end
      end
      ST_DELAY: begin
        if (host_up) begin
          seq_st = ST_WAIT_OFF;
        end else if (overdue(w.now_ms)) begin
          switch_power(1'b0);
          if (on_battery) begin
            pf_sticky = 1'b1;
            seq_st    = ST_WAIT_POWER;
          end else begin
            seq_st = ST_WAIT_BUTTON;
          end
        end
      end
      ST_WAIT_BUTTON: begin
        if (released) begin
          switch_power(1'b1);
          seq_st = ST_WAIT_ON;
        end
      end
      ST_WAIT_POWER: begin
        if (mains_on) begin
          due_ms = w.now_ms + TIME_BITS'(dly_cfg);
          seq_st = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (!mains_on) begin
          due_ms = w.now_ms + TIME_BITS'(dly_cfg);
        end else if (overdue(w.now_ms)) begin
          switch_power(1'b1);
          seq_st = ST_WAIT_ON;
        end
      end
      default: seq_st = ST_WAIT_ON;
    endcase
    states_seen[seq_st] = 1'b1;
    r.host_power_on      = pwr_on;
    r.power_wait_flag    = pwr_changed;
    r.powerfail_shutdown = pf_sticky;
    r.mains_flag         = mains_on;
    r.battery_flag       = on_battery;
    r.button_flag        = btn_held;
    r.host_online_flag   = host_up;
    r.sequencer_state    = seq_st;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Shared bench state
  // --------------------------------------------------------------------------
  result_t     status_q[$];       // status words still owed by the block
  int unsigned fail_cnt     = 0;
  int unsigned words_sent   = 0;
  int unsigned words_back   = 0;
  int unsigned settings_cnt = 1;  // reset values count as the first
  int unsigned src_idle_pct = 37;
  int unsigned snk_idle_pct = 62;
  int unsigned hold_off_len = 0;  // long receiver stall requested by main

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long hold-off on request
  // --------------------------------------------------------------------------
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Status checker: oldest owed word against each word the block hands over
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_back++;
      if (status_q.size() == 0) begin
        $error("status word 0x%h with nothing owed", m_axis_tdata);
        fail_cnt++;
      end else begin
        want = status_q.pop_front();
        check_field("host_power_on",      want.host_power_on,      m_axis_tdata[0]);
        check_field("power_wait_flag",    want.power_wait_flag,    m_axis_tdata[1]);
        check_field("powerfail_shutdown", want.powerfail_shutdown, m_axis_tdata[2]);
        check_field("mains_flag",         want.mains_flag,         m_axis_tdata[3]);
        check_field("battery_flag",       want.battery_flag,       m_axis_tdata[4]);
        check_field("button_flag",        want.button_flag,        m_axis_tdata[5]);
        check_field("host_online_flag",   want.host_online_flag,   m_axis_tdata[6]);
        check_field("sequencer_state",    want.sequencer_state,    m_axis_tdata[9:7]);
      end
    end
  end

  // Watchdog: ends the run if neither side moves a word for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d status words owed",
               IDLE_LIMIT, status_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks; each returns just after a rising edge
  // --------------------------------------------------------------------------

  // offer one pass word, wait for it to be taken, then book its status
  task automatic offer_pass(input in_item_t w, input logic pinned,
                            input result_t pinned_status);
    result_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, w.host_online_level, w.supply_code, w.button_level,
                      w.now_ms};
    s_axis_tuser  <= w.sample_strobe;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = loop_pass(w);
    status_q.push_back(pinned ? pinned_status : predicted);
    words_sent++;
  endtask

  // wait until every owed status is back, plus a little for the pipe
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write both registers back to back; threshold gets noise in its spare bits
  task automatic load_settings(input logic [ADC_BITS-1:0] thr,
                               input logic [DLY_BITS-1:0] dly);
    logic [CFG_DATA_BITS-1:0] thr_word;
    thr_word    = {6'($urandom), thr};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_AC_THRESHOLD;
    cfg_wdata_i <= thr_word;
    @(posedge clk_i);
    thr_cfg     = thr_word[ADC_BITS-1:0];
    cfg_index_i <= CFG_OFF_DELAY;
    cfg_wdata_i <= dly;
    @(posedge clk_i);
    dly_cfg     = dly;
    cfg_we_i    <= 1'b0;
    settings_cnt++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_item_t             w;
    logic                 mains_sim;
    logic                 host_sim;
    logic                 btn_sim;
    logic [TIME_BITS-1:0] clock_ms;
    int unsigned          step;

    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_AC_THRESHOLD;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed passes under reset register values
    for (int i = 0; i < N_PROBES; i++) begin
      offer_pass(PROBES[i].pass, PROBES[i].pinned, PROBES[i].status);
    end
    drain();

    // random activity: a supply that comes and goes, a host that boots and
    // shuts down, a button pressed now and then, mostly steady time
    mains_sim = 1'b1;
    host_sim  = 1'b0;
    btn_sim   = 1'b1;
    clock_ms  = $urandom();
    for (int seg = 0; seg < N_SEGS; seg++) begin
      case (seg / 2)
        0: begin src_idle_pct = 37; snk_idle_pct = 62; end
        1: begin src_idle_pct = 62; snk_idle_pct = 37; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      load_settings(THR_SET[seg], DLY_SET[seg]);
      // block fills up behind a stalled receiver while words keep coming
      if (seg == 4) hold_off_len = 64;
      for (int n = 0; n < SEG_WORDS; n++) begin
        if ($urandom_range(14) == 0) mains_sim = !mains_sim;
        if ($urandom_range(5) == 0)  host_sim  = !host_sim;
        if ($urandom_range(3) == 0)  btn_sim   = !btn_sim;
        step = $urandom_range(dly_cfg / 4 + 3);
        if ($urandom_range(63) == 0) begin
          clock_ms = $urandom();
        end else begin
          clock_ms = clock_ms + step;
        end
        w.now_ms        = clock_ms;
        w.button_level  = btn_sim;
        w.sample_strobe = ($urandom_range(9) < 7);
        if ($urandom_range(9) == 0) begin
          w.supply_code = $urandom_range(1023);
        end else if (mains_sim) begin
          w.supply_code = $urandom_range(1023, thr_cfg);
        end else begin
          w.supply_code = (thr_cfg == 0) ? '0 : $urandom_range(thr_cfg - 1, 0);
        end
        w.host_online_level = ($urandom_range(19) == 0) ? 1'($urandom()) : host_sim;
        offer_pass(w, 1'b0, NO_STATUS);
      end
      drain();
    end

    // stray words would show up here
    repeat (8) @(posedge clk_i);

    $display("%0d loop-pass words in, %0d status words checked, %0d register settings",
             words_sent, words_back, settings_cnt);
    $display("sequencer states reached (6..0): %07b, %0d mismatches",
             states_seen, fail_cnt);
    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
